// File: rtl/core/etf_pkg.sv
package etf_pkg;

   localparam int TAG_WORD_CHARS = 8;
   localparam int TAG_LEN_W = $clog2(TAG_WORD_CHARS + 2);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [TAG_WORD_CHARS-1:0][7:0] tag_word_type;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // tag words shift in from the right, so a name is its string zero-extended
   localparam tag_word_type WORD_PARAM  = {{(TAG_WORD_CHARS - 5) * 8{1'b0}}, "param"};
   localparam tag_word_type WORD_NOFILL = {{(TAG_WORD_CHARS - 6) * 8{1'b0}}, "nofill"};
   localparam tag_word_type WORD_ENDFILL = {{(TAG_WORD_CHARS - 7) * 8{1'b0}}, "/nofill"};
   localparam logic [TAG_LEN_W-1:0] LEN_PARAM   = TAG_LEN_W'(5);
   localparam logic [TAG_LEN_W-1:0] LEN_NOFILL  = TAG_LEN_W'(6);
   localparam logic [TAG_LEN_W-1:0] LEN_ENDFILL = TAG_LEN_W'(7);

   // closing text, character 0 at the top byte
   localparam logic [7:0][7:0] CLOSE_TEXT = "</param>";

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] first_char;
      logic [7:0] second_char;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
             c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
   endfunction

endpackage

// File: rtl/core/etf_parser.sv
module etf_parser
   import etf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output result_type result
);

   typedef enum logic [1:0] {
      MODE_TEXT  = 2'd0,
      MODE_TAG   = 2'd1,
      MODE_PARAM = 2'd2
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic                   no_fill_ff, no_fill_in;
   logic                   after_nl_ff, after_nl_in;
   logic                   space_ff, space_in;
   logic                   cr_seen_ff, cr_seen_in;
   tag_word_type           word_ff, word_in;
   logic [TAG_LEN_W-1:0]   len_ff, len_in;
   logic                   ended_ff, ended_in;
   logic [2:0]             close_pos_ff, close_pos_in;
   logic [7:0]             lower;
   logic                   line_end;

   always_comb begin
      lower = in_byte;
      if (in_byte >= CHAR_UPPER_A && in_byte <= CHAR_UPPER_Z) begin
         lower = in_byte + CASE_OFFSET;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      no_fill_in   = no_fill_ff;
      after_nl_in  = after_nl_ff;
      space_in     = space_ff;
      cr_seen_in   = 1'b0;
      word_in      = word_ff;
      len_in       = len_ff;
      ended_in     = ended_ff;
      close_pos_in = close_pos_ff;
      line_end     = 1'b0;
      result       = '0;
      case (mode_ff)
         MODE_TAG: begin
            if (in_byte == CHAR_GT) begin
               mode_in = MODE_TEXT;
               if (!ended_ff && len_ff == LEN_PARAM && word_ff == WORD_PARAM) begin
                  mode_in      = MODE_PARAM;
                  close_pos_in = '0;
               end else if (len_ff == LEN_NOFILL && word_ff == WORD_NOFILL) begin
                  no_fill_in = 1'b1;
               end else if (len_ff == LEN_ENDFILL && word_ff == WORD_ENDFILL) begin
                  no_fill_in = 1'b0;
               end
            end else if (is_blank(in_byte)) begin
               ended_in = 1'b1;
            end else if (!ended_ff) begin
               if (len_ff < TAG_LEN_W'(TAG_WORD_CHARS)) begin
                  word_in = {word_ff[TAG_WORD_CHARS-2:0], lower};
                  len_in  = len_ff + 1'b1;
               end else begin
                  len_in = TAG_LEN_W'(TAG_WORD_CHARS + 1);
               end
            end
         end
         MODE_PARAM: begin
            if (in_byte == CLOSE_TEXT[3'd7 - close_pos_ff]) begin
               close_pos_in = close_pos_ff + 1'b1;
               if (close_pos_ff == 3'd7) begin
                  mode_in = MODE_TEXT;
               end
            end else begin
               close_pos_in = (in_byte == CHAR_LT) ? 3'd1 : 3'd0;
            end
         end
         default: begin
            if (in_byte == CHAR_LT) begin
               mode_in  = MODE_TAG;
               word_in  = '0;
               len_in   = '0;
               ended_in = 1'b0;
            end else if (in_byte == CHAR_CR) begin
               line_end   = 1'b1;
               cr_seen_in = 1'b1;
            end else if (in_byte == CHAR_LF) begin
               line_end = !cr_seen_ff;
            end else begin
               after_nl_in = 1'b0;
               if (!no_fill_ff && space_ff) begin
                  space_in           = 1'b0;
                  result.count       = 2'd2;
                  result.first_char  = CHAR_SPACE;
                  result.second_char = in_byte;
               end else begin
                  result.count      = 2'd1;
                  result.first_char = in_byte;
               end
            end
            if (line_end) begin
               after_nl_in = 1'b1;
               if (!no_fill_ff && !after_nl_ff) begin
                  space_in = 1'b1;
               end else begin
                  if (!no_fill_ff) begin
                     space_in = 1'b0;
                  end
                  result.count      = 2'd1;
                  result.first_char = CHAR_LF;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         no_fill_ff   <= 1'b0;
         after_nl_ff  <= 1'b1;
         space_ff     <= 1'b0;
         cr_seen_ff   <= 1'b0;
         word_ff      <= '0;
         len_ff       <= '0;
         ended_ff     <= 1'b0;
         close_pos_ff <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         no_fill_ff   <= no_fill_in;
         after_nl_ff  <= after_nl_in;
         space_ff     <= space_in;
         cr_seen_ff   <= cr_seen_in;
         word_ff      <= word_in;
         len_ff       <= len_in;
         ended_ff     <= ended_in;
         close_pos_ff <= close_pos_in;
      end
   end

   // two results only ever come from a space put in front of a text byte
   a_pair_is_space: assert property (@(posedge clock) disable iff (reset)
      result.count == 2'd2 |-> result.first_char == CHAR_SPACE && !no_fill_ff)
      else $error("pair without leading space");

   a_tag_silent: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_TEXT |-> result.count == 2'd0)
      else $error("result from inside a tag");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= TAG_LEN_W'(TAG_WORD_CHARS + 1))
      else $error("tag word length out of range");

endmodule

// File: rtl/core/etf_rsp_queue.sv
module etf_rsp_queue
   import etf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type result,
   output logic       has_room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic [QUEUE_DEPTH-1:0][7:0] char_ff;
   logic [QUEUE_DEPTH-1:0]      last_ff;
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic [QUEUE_PTR_W-1:0]      wr_next;
   logic [1:0]                  push_cnt;
   logic                        pop;

   assign push_cnt        = push ? result.count : 2'd0;
   assign pop             = rsp_valid && rsp_ready;
   assign rsp_valid       = count_ff != '0;
   assign rsp_out_byte    = char_ff[rd_ptr_ff];
   assign rsp_last_of_run = last_ff[rd_ptr_ff];
   assign has_room        = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign wr_next         = wr_ptr_ff + 1'b1;
   assign count_in        = count_ff + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         char_ff[wr_ptr_ff] <= result.first_char;
         last_ff[wr_ptr_ff] <= push_cnt == 2'd1;
      end
      if (push_cnt == 2'd2) begin
         char_ff[wr_next] <= result.second_char;
         last_ff[wr_next] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not decremented on pop");

endmodule

// File: rtl/core/enriched_text_filter.sv
// Enriched text to plain text filter.
// req channel: one byte of enriched text per request (req_in_byte).
// rsp channel: plain-text bytes (rsp_out_byte); rsp_last_of_run marks the
// final byte caused by a request. A request may cause no byte at all (tags,
// param bodies, the first line end of a run while fill is on), one byte, or
// two bytes when a pending space goes out ahead of a text byte.
// Results are registered in the queue before they are offered on rsp.
// Throughput: one request per cycle while req_ready is high; the parser
// state updates in the cycle of acceptance and results go into a four-entry
// queue. req_ready is low while fewer than two queue entries are free, so a
// long run of spaced words is limited by the single-byte rsp port.
// Reset (synchronous) returns to text mode with fill on and empties the
// queue. When the receiver stalls, the queue holds its contents and fills;
// req_ready then drops until entries drain.
module enriched_text_filter
   import etf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   result_type result;
   logic       accept;

   assign accept = req_valid && req_ready;

   etf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .result  (result)
   );

   etf_rsp_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (accept),
      .result          (result),
      .has_room        (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
